### rtl/core/qpps_pkg.sv
// qpps_pkg: shared types, constants and helpers for the QPSK polyphase pulse shaper.
// Used by qpps_ctrl, qpps_datapath and qpsk_polyphase_pulse_shaper_unit.
// No dependencies.
`default_nettype none

package qpps_pkg;

  localparam int unsigned MAX_PHASES = 32;
  localparam int unsigned MAX_TAPS   = 16;
  localparam int unsigned TAP_DEPTH  = MAX_PHASES * MAX_TAPS;
  localparam int unsigned TAP_AW     = $clog2(TAP_DEPTH);
  localparam int unsigned WIN_AW     = $clog2(MAX_TAPS);
  localparam int unsigned PHASE_W    = 7;
  localparam int unsigned ACC_W      = 21;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP_RATIO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIM_STEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_PER_PHASE = 2'd2;

  // item kinds
  localparam logic KIND_SYMBOL = 1'b0;
  localparam logic KIND_TAP    = 1'b1;

  // window entry codes, a 2-bit signed value
  localparam logic [1:0] WIN_ZERO = 2'b00;
  localparam logic [1:0] WIN_POS  = 2'b01;
  localparam logic [1:0] WIN_NEG  = 2'b11;

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(SAMPLE_MAX);
  localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(SAMPLE_MIN);

  typedef struct packed {
    logic               kind;
    logic [1:0]         symbol;
    logic [8:0]         tap_index;
    logic signed [15:0] tap_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] i_sample;
    logic signed [15:0] q_sample;
    logic               last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic sym_write;
    logic tap_write;
    logic tap_start;
    logic tap_issue;
    logic emit;
    logic phase_wrap;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic phase_lt_ratio;
    logic tap_last;
    logic out_free;
  } sts_t;

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [15:0] r;
    if (v > ACC_HI) begin
      r = SAMPLE_MAX;
    end else if (v < ACC_LO) begin
      r = SAMPLE_MIN;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/qpps_ctrl.sv
// qpps_ctrl: sequencer for symbol items, tap loads and per-sample tap walks.
// Depends on qpps_pkg (cmd_t, sts_t, item kinds).
`default_nettype none

module qpps_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_kind,
  output logic               in_stall,
  input  wire qpps_pkg::sts_t sts,
  output qpps_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RUN,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_kind == qpps_pkg::KIND_TAP) begin
            cmd.tap_write = 1'b1;
          end else begin
            cmd.sym_write = 1'b1;
            state_nxt     = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.phase_lt_ratio) begin
          cmd.tap_start = 1'b1;
          state_nxt     = S_RUN;
        end else begin
          cmd.phase_wrap = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_RUN: begin
        cmd.tap_issue = 1'b1;
        if (sts.tap_last) begin
          state_nxt = S_DRAIN;
        end
      end
      // last tap product lands in the accumulators
      S_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/qpps_datapath.sv
// qpps_datapath: config registers, tap memory, symbol windows, phase accumulator,
// multiply-accumulate and output register. Depends on qpps_pkg.
`default_nettype none

module qpps_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire qpps_pkg::in_item_t                 in_data,
  input  wire qpps_pkg::cmd_t                     cmd,
  output qpps_pkg::sts_t                          sts,
  input  wire logic                               cfg_valid,
  input  wire logic [qpps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [qpps_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               out_stall,
  output logic                                    out_valid,
  output qpps_pkg::out_item_t                     out_data
);

  localparam int unsigned AW  = qpps_pkg::TAP_AW;
  localparam int unsigned WAW = qpps_pkg::WIN_AW;
  localparam int unsigned PW  = qpps_pkg::PHASE_W;
  localparam int unsigned AC  = qpps_pkg::ACC_W;

  // configuration
  logic [5:0] interp_ratio_r;
  logic [5:0] decim_step_r;
  logic [4:0] taps_per_phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interp_ratio_r   <= 6'd1;
      decim_step_r     <= 6'd1;
      taps_per_phase_r <= 5'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        qpps_pkg::CFG_INTERP_RATIO:   interp_ratio_r   <= cfg_data;
        qpps_pkg::CFG_DECIM_STEP:     decim_step_r     <= cfg_data;
        qpps_pkg::CFG_TAPS_PER_PHASE: taps_per_phase_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // clamp at use
  logic [5:0] ratio_c;
  logic [5:0] step_c;
  logic [4:0] len_c;
  logic [4:0] len_m1;

  always_comb begin
    if (interp_ratio_r == 6'd0) begin
      ratio_c = 6'd1;
    end else if (interp_ratio_r > 6'(qpps_pkg::MAX_PHASES)) begin
      ratio_c = 6'(qpps_pkg::MAX_PHASES);
    end else begin
      ratio_c = interp_ratio_r;
    end
    if (decim_step_r == 6'd0) begin
      step_c = 6'd1;
    end else if (decim_step_r > 6'd32) begin
      step_c = 6'd32;
    end else begin
      step_c = decim_step_r;
    end
    if (taps_per_phase_r == 5'd0) begin
      len_c = 5'd1;
    end else if (taps_per_phase_r > 5'(qpps_pkg::MAX_TAPS)) begin
      len_c = 5'(qpps_pkg::MAX_TAPS);
    end else begin
      len_c = taps_per_phase_r;
    end
    len_m1 = len_c - 5'd1;
  end

  // symbol windows
  logic [1:0]     i_win_r [qpps_pkg::MAX_TAPS];
  logic [1:0]     q_win_r [qpps_pkg::MAX_TAPS];
  logic [WAW-1:0] write_pos_r;
  logic [WAW-1:0] wr_pos;
  logic [4:0]     wr_pos_p1;
  logic [WAW-1:0] write_pos_nxt;
  logic [1:0]     i_code;
  logic [1:0]     q_code;

  always_comb begin
    wr_pos = ({1'b0, write_pos_r} >= len_c) ? '0 : write_pos_r;
    wr_pos_p1 = {1'b0, wr_pos} + 5'd1;
    write_pos_nxt = (wr_pos_p1 >= len_c) ? '0 : wr_pos_p1[WAW-1:0];
    i_code = in_data.symbol[1] ? qpps_pkg::WIN_POS : qpps_pkg::WIN_NEG;
    q_code = in_data.symbol[0] ? qpps_pkg::WIN_POS : qpps_pkg::WIN_NEG;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < qpps_pkg::MAX_TAPS; k++) begin
        i_win_r[k] <= qpps_pkg::WIN_ZERO;
        q_win_r[k] <= qpps_pkg::WIN_ZERO;
      end
      write_pos_r <= '0;
    end else if (cmd.sym_write) begin
      i_win_r[wr_pos] <= i_code;
      q_win_r[wr_pos] <= q_code;
      write_pos_r     <= write_pos_nxt;
    end
  end

  // phase accumulator
  logic [PW-1:0] phase_acc_r;
  logic [PW-1:0] phase_step;

  assign phase_step = phase_acc_r + PW'(step_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
    end else if (cmd.emit) begin
      phase_acc_r <= phase_step;
    end else if (cmd.phase_wrap) begin
      phase_acc_r <= phase_acc_r - PW'(ratio_c);
    end
  end

  // tap walk: address, window index, tap count
  logic [AW-1:0]  addr_r;
  logic [WAW-1:0] w_r;
  logic [WAW-1:0] y_r;
  logic [9:0]     base_prod;

  // phase is below the ratio here, so it fits five bits
  assign base_prod = phase_acc_r[4:0] * len_c;

  always_ff @(posedge clk) begin
    if (cmd.tap_start) begin
      addr_r <= base_prod[AW-1:0];
      w_r    <= write_pos_r;
      y_r    <= '0;
    end else if (cmd.tap_issue) begin
      addr_r <= addr_r + AW'(1);
      w_r    <= (w_r == len_m1[WAW-1:0]) ? '0 : w_r + WAW'(1);
      y_r    <= y_r + WAW'(1);
    end
  end

  // tap memory, no reset
  logic signed [15:0] tap_mem [qpps_pkg::TAP_DEPTH];
  logic signed [15:0] rd_data_r;
  logic [1:0]         i_rd_r;
  logic [1:0]         q_rd_r;
  logic               prod_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.tap_write) begin
      tap_mem[in_data.tap_index] <= in_data.tap_value;
    end
    if (cmd.tap_issue) begin
      rd_data_r <= tap_mem[addr_r];
      i_rd_r    <= i_win_r[w_r];
      q_rd_r    <= q_win_r[w_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.tap_issue;
    end
  end

  // accumulate +/- tap
  logic signed [AC-1:0] tap_ext;
  logic signed [AC-1:0] i_term;
  logic signed [AC-1:0] q_term;
  logic signed [AC-1:0] acc_i_r;
  logic signed [AC-1:0] acc_q_r;

  assign tap_ext = {{(AC-16){rd_data_r[15]}}, rd_data_r};

  always_comb begin
    case (i_rd_r)
      qpps_pkg::WIN_POS: i_term = tap_ext;
      qpps_pkg::WIN_NEG: i_term = -tap_ext;
      default:           i_term = '0;
    endcase
    case (q_rd_r)
      qpps_pkg::WIN_POS: q_term = tap_ext;
      qpps_pkg::WIN_NEG: q_term = -tap_ext;
      default:           q_term = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.tap_start) begin
      acc_i_r <= '0;
      acc_q_r <= '0;
    end else if (prod_vld_r) begin
      acc_i_r <= acc_i_r + i_term;
      acc_q_r <= acc_q_r + q_term;
    end
  end

  // output register
  logic                out_valid_r;
  qpps_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.i_sample <= qpps_pkg::sat16(acc_i_r);
      out_data_r.q_sample <= qpps_pkg::sat16(acc_q_r);
      out_data_r.last     <= (phase_step >= PW'(ratio_c));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sts.phase_lt_ratio = (phase_acc_r < PW'(ratio_c));
    sts.tap_last       = (y_r == len_m1[WAW-1:0]);
    sts.out_free       = !out_valid_r || !out_stall;
  end

endmodule

`default_nettype wire

### rtl/core/qpsk_polyphase_pulse_shaper_unit.sv
// Each output sample: the sequencer checks the phase, then walks len taps (len = clamped
// taps_per_phase) through the single tap-memory read port, one tap per cycle, drains the last
// product and emits once the output is free. The input stalls until a symbol's samples are all
// emitted; a tap load is taken while idle without stalling.
// Reset (synchronous, rst_n low): registers to 1, windows, write position and
// phase to zero; the tap memory is not cleared.
`default_nettype none

module qpsk_polyphase_pulse_shaper_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire qpps_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output qpps_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [qpps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [qpps_pkg::CFG_DATA_W-1:0] cfg_data
);

  qpps_pkg::cmd_t cmd;
  qpps_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  qpps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  qpps_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for qpsk_polyphase_pulse_shaper_unit.
// Depends on qpps_pkg (item structs, register indexes, window codes, limits).
// A behavioral predictor checks every output sample against directed and random stimulus.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS   = 12;
  // taps that any test configuration can read
  localparam int unsigned TAP_LOADED    = 64;
  localparam longint unsigned TIMEOUT_NS = 64'd50_000_000;
  localparam logic [qpps_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  qpps_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  qpps_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [qpps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [qpps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  qpsk_polyphase_pulse_shaper_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [5:0]         sh_ratio;
  logic [5:0]         sh_step;
  logic [4:0]         sh_len;
  logic signed [15:0] coef_mem [qpps_pkg::TAP_DEPTH];
  logic [1:0]         win_i [qpps_pkg::MAX_TAPS];
  logic [1:0]         win_q [qpps_pkg::MAX_TAPS];
  logic [3:0]         win_pos;
  logic [6:0]         phase_acc;

  qpps_pkg::out_item_t expected_samples [$];
  int unsigned err_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // long receiver hold-off, requested by bumping hold_req
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_samples
    qpps_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        err_count++;
        $display("%0t: unexpected sample i=%0d q=%0d last=%0b", $time,
                 out_data.i_sample, out_data.q_sample, out_data.last);
      end else begin
        want = expected_samples.pop_front();
        if (out_data.i_sample !== want.i_sample) begin
          err_count++;
          $display("%0t: i_sample expected %0d got %0d", $time,
                   want.i_sample, out_data.i_sample);
        end
        if (out_data.q_sample !== want.q_sample) begin
          err_count++;
          $display("%0t: q_sample expected %0d got %0d", $time,
                   want.q_sample, out_data.q_sample);
        end
        if (out_data.last !== want.last) begin
          err_count++;
          $display("%0t: last expected %0b got %0b", $time, want.last, out_data.last);
        end
      end
    end
  end

  function automatic int unsigned clamp_field(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [15:0] clip16(input int v);
    if (v > int'(qpps_pkg::SAMPLE_MAX)) return qpps_pkg::SAMPLE_MAX;
    if (v < int'(qpps_pkg::SAMPLE_MIN)) return qpps_pkg::SAMPLE_MIN;
    return v[15:0];
  endfunction

  // one transfer on the input channel -> coefficient write or a burst of samples
  task automatic predict_samples(input qpps_pkg::in_item_t item);
    int unsigned ratio, step, len, base, w, n, y;
    int acc_i, acc_q;
    logic [8:0] addr;
    qpps_pkg::out_item_t smp, prev;
    logic have_prev;
    if (item.kind == qpps_pkg::KIND_TAP) begin
      coef_mem[item.tap_index] = item.tap_value;
    end else begin
      ratio = clamp_field(32'(sh_ratio), 1, qpps_pkg::MAX_PHASES);
      step  = clamp_field(32'(sh_step), 1, 32);
      len   = clamp_field(32'(sh_len), 1, qpps_pkg::MAX_TAPS);
      if (win_pos >= len) win_pos = '0;
      win_i[win_pos] = item.symbol[1] ? qpps_pkg::WIN_POS : qpps_pkg::WIN_NEG;
      win_q[win_pos] = item.symbol[0] ? qpps_pkg::WIN_POS : qpps_pkg::WIN_NEG;
      win_pos = win_pos + 4'd1;
      if (win_pos >= len) win_pos = '0;
      n = 0;
      have_prev = 1'b0;
      while (phase_acc < ratio && n < qpps_pkg::MAX_PHASES) begin
        acc_i = 0;
        acc_q = 0;
        base = phase_acc * len;
        // oldest window entry first
        for (y = 0; y < len; y++) begin
          w = win_pos + y;
          if (w >= len) w -= len;
          addr = 9'((base + y) % qpps_pkg::TAP_DEPTH);
          acc_i += int'($signed(win_i[w])) * int'(coef_mem[addr]);
          acc_q += int'($signed(win_q[w])) * int'(coef_mem[addr]);
        end
        smp.i_sample = clip16(acc_i);
        smp.q_sample = clip16(acc_q);
        smp.last = 1'b0;
        if (have_prev) expected_samples.push_back(prev);
        prev = smp;
        have_prev = 1'b1;
        n++;
        phase_acc = phase_acc + 7'(step);
      end
      if (have_prev) begin
        prev.last = 1'b1;
        expected_samples.push_back(prev);
      end
      phase_acc = phase_acc - 7'(ratio);
    end
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input qpps_pkg::in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_samples(item);
    @(negedge clk);
  endtask

  task automatic send_symbol(input logic [1:0] sym);
    qpps_pkg::in_item_t it;
    it.kind      = qpps_pkg::KIND_SYMBOL;
    it.symbol    = sym;
    it.tap_index = 9'($urandom);
    it.tap_value = 16'($urandom);
    send_item(it);
  endtask

  task automatic send_tap(input logic [8:0] idx, input logic signed [15:0] val);
    qpps_pkg::in_item_t it;
    it.kind      = qpps_pkg::KIND_TAP;
    it.symbol    = 2'($urandom);
    it.tap_index = idx;
    it.tap_value = val;
    send_item(it);
  endtask

  // wait until every sample has come out and the block has gone quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [qpps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [qpps_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      qpps_pkg::CFG_INTERP_RATIO:   sh_ratio = val;
      qpps_pkg::CFG_DECIM_STEP:     sh_step = val;
      qpps_pkg::CFG_TAPS_PER_PHASE: sh_len = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [5:0] ratio, input logic [5:0] step,
                            input logic [5:0] len);
    wait_idle();
    write_reg(qpps_pkg::CFG_INTERP_RATIO, ratio);
    write_reg(qpps_pkg::CFG_DECIM_STEP, step);
    write_reg(qpps_pkg::CFG_TAPS_PER_PHASE, len);
  endtask

  task automatic set_idling(input int unsigned profile);
    case (profile % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
      default: begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  // half full-scale, half small coefficients so both clipped and linear sums occur
  function automatic logic signed [15:0] rand_tap();
    int v;
    if ($urandom_range(1) == 0) begin
      v = int'($urandom_range(65535)) - 32768;
    end else begin
      v = int'($urandom_range(4095)) - 2048;
    end
    return v[15:0];
  endfunction

  // every coefficient that a test configuration can reach is written first
  task automatic load_tap_store();
    int unsigned k;
    for (k = 0; k < TAP_LOADED; k++) begin
      if (k == 0) send_tap(9'(k), qpps_pkg::SAMPLE_MIN);
      else if (k == TAP_LOADED - 1) send_tap(9'(k), qpps_pkg::SAMPLE_MAX);
      else send_tap(9'(k), rand_tap());
    end
  endtask

  // reset registers, then a longer window whose unwritten entries are still zero
  task automatic test_reset_state();
    int unsigned s;
    for (s = 0; s < 4; s++) send_symbol(2'(s));
    set_config(6'd1, 6'd1, 6'd16);
    send_symbol(2'd3);
    send_symbol(2'd0);
  endtask

  task automatic test_saturation();
    send_tap(9'd0, qpps_pkg::SAMPLE_MAX);
    send_tap(9'd1, qpps_pkg::SAMPLE_MAX);
    set_config(6'd1, 6'd1, 6'd2);
    send_symbol(2'd3);
    send_symbol(2'd3);
    send_symbol(2'd0);
    send_symbol(2'd0);
    // negative full-scale tap against a negative symbol overflows upward
    send_tap(9'd0, qpps_pkg::SAMPLE_MIN);
    set_config(6'd1, 6'd1, 6'd1);
    send_symbol(2'd0);
    send_symbol(2'd3);
  endtask

  task automatic test_register_clamp();
    // ratio clamps to 32 branches, zero step and zero length to 1: 32 samples per symbol
    set_config(6'd63, 6'd0, 6'd0);
    send_symbol(2'd1);
    send_symbol(2'd2);
    wait_idle();
    write_reg(CFG_UNUSED, 6'd63);
    // step far above the ratio, window clamps to 16 taps: most symbols give nothing
    set_config(6'd0, 6'd33, 6'd63);
    send_symbol(2'd3);
    send_symbol(2'd0);
    send_symbol(2'd1);
  endtask

  // shrinking the window below the write position restarts it at zero
  task automatic test_window_shrink();
    int unsigned s;
    set_config(6'd4, 6'd3, 6'd12);
    for (s = 0; s < 6; s++) send_symbol(2'($urandom));
    set_config(6'd4, 6'd3, 6'd5);
    send_symbol(2'd2);
    send_symbol(2'd1);
  endtask

  task automatic pick_config();
    if ($urandom_range(3) == 0) begin
      // full-width ratio and step; a short window keeps reads in the loaded taps
      set_config(6'($urandom), 6'($urandom), 6'($urandom_range(2)));
    end else begin
      set_config(6'($urandom_range(1, 8)), 6'($urandom_range(1, 6)),
                 6'($urandom_range(1, 6)));
    end
  endtask

  task automatic send_random(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < 15) send_tap(9'($urandom), rand_tap());
      else send_symbol(2'($urandom));
    end
  endtask

  task automatic test_random();
    int unsigned p;
    for (p = 0; p < RAND_PHASES; p++) begin
      pick_config();
      set_idling(p);
      send_random(PHASE_ITEMS);
    end
  endtask

  // receiver holds off while the sender keeps offering symbols
  task automatic test_backpressure();
    set_config(6'd4, 6'd1, 6'd4);
    set_idling(0);
    @(posedge clk);
    hold_req++;
    @(negedge clk);
    send_random(12);
    wait_idle();
  endtask

  // sender pauses mid-stream until the output has drained
  task automatic test_sender_pause();
    set_config(6'd3, 6'd2, 6'd8);
    set_idling(3);
    send_random(10);
    wait_idle();
    send_random(10);
  endtask

  initial begin
    sh_ratio  = 6'd1;
    sh_step   = 6'd1;
    sh_len    = 5'd1;
    win_pos   = '0;
    phase_acc = '0;
    for (int k = 0; k < qpps_pkg::MAX_TAPS; k++) begin
      win_i[k] = qpps_pkg::WIN_ZERO;
      win_q[k] = qpps_pkg::WIN_ZERO;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    load_tap_store();
    test_reset_state();
    test_saturation();
    test_register_clamp();
    test_window_shrink();
    test_random();
    test_backpressure();
    test_sender_pause();

    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
rtl/core/qpps_pkg.sv
rtl/core/qpps_ctrl.sv
rtl/core/qpps_datapath.sv
rtl/core/qpsk_polyphase_pulse_shaper_unit.sv
test/testbench.sv
